[hdl/fptdt_pkg.sv]
// ----------------------------------------------------------------------------
// fptdt_pkg
// Shared types and constants for the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package fptdt_pkg;

	localparam int DIGIT_W = 4;

	localparam logic [6:0] ASCII_ZERO  = 7'h30;
	localparam logic [6:0] ASCII_MINUS = 7'h2D;
	localparam logic [6:0] ASCII_DOT   = 7'h2E;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_INT,
		ST_DOT,
		ST_FRAC
	} fptdt_state_t;

endpackage

[hdl/fptdt_bcd.sv]
// ----------------------------------------------------------------------------
// fptdt_bcd
// Iterative binary to BCD converter: one input bit per cycle through a shared
// add-3 and shift unit. done pulses for one cycle when bcd is valid.
// ----------------------------------------------------------------------------
module fptdt_bcd #(
	parameter int IN_W   = 24,
	parameter int DIGITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [IN_W-1:0]                       value,
	output logic                                  done,
	output logic [DIGITS*fptdt_pkg::DIGIT_W-1:0]  bcd
);

	localparam int BW    = DIGITS * fptdt_pkg::DIGIT_W;
	localparam int CNT_W = $clog2(IN_W + 1);

	logic [IN_W-1:0]  shift_q;
	logic [BW-1:0]    bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BW-1:0]    adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*fptdt_pkg::DIGIT_W +: fptdt_pkg::DIGIT_W] >= 4'd5) begin
				adj[i*fptdt_pkg::DIGIT_W +: fptdt_pkg::DIGIT_W] =
					bcd_q[i*fptdt_pkg::DIGIT_W +: fptdt_pkg::DIGIT_W] + 4'd3;
			end else begin
				adj[i*fptdt_pkg::DIGIT_W +: fptdt_pkg::DIGIT_W] =
					bcd_q[i*fptdt_pkg::DIGIT_W +: fptdt_pkg::DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(IN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= value;
			bcd_q   <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << 1;
			bcd_q   <= {adj[BW-2:0], shift_q[IN_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

[hdl/fixed_point_to_decimal_text.sv]
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_text
// Converts a signed fixed-point number into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with number_value, a two's complement
// number carrying FRAC_BITS fraction bits. Output channel: out_valid /
// out_stall with one ASCII character per item in text_char; last_char marks
// the final character of a number's text. cfg_write loads cfg_data into the
// decimal count (reset 1, saturated at MAX_DECIMALS).
// Text: optional '-', integer digits without leading zeros, then '.' and the
// truncated fraction digits when the decimal count is non-zero.
// The integer part goes through a bit-serial BCD converter; then a leading
// '-' is sent if the number is negative, leading zero digits are dropped
// and the first digit goes out. Characters then follow at one per cycle
// while out_stall is low. A new number is not taken until the last
// character of the one before is in the output register; in_stall is high
// while a number is being converted.
// Reset clears the sequencer and the output valid flag. A stalled output
// holds its character and the sequencer waits for it.
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_text #(
	parameter int FRAC_BITS    = 8,
	parameter int MAX_DECIMALS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] number_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  text_char,
	output logic        last_char
);

	localparam int WB     = 32 - FRAC_BITS;
	localparam int DIGITS = (WB * 301) / 1000 + 1;
	localparam int BW     = DIGITS * fptdt_pkg::DIGIT_W;
	localparam int DC_W   = $clog2(DIGITS + 1);
	localparam int FW     = (FRAC_BITS > 0) ? FRAC_BITS : 1;
	localparam int PW     = FW + 4;
	localparam logic [FW-1:0] FMASK = FW'((64'd1 << FRAC_BITS) - 64'd1);

	fptdt_pkg::fptdt_state_t state_q, state_d;

	logic [2:0]      decimals_q;
	logic            neg_q;
	logic [FW-1:0]   frac_q;
	logic [3:0]      decs_q;
	logic [3:0]      fcnt_q;
	logic [BW-1:0]   dig_q;
	logic [DC_W-1:0] dcnt_q;
	logic [6:0]      char_q;
	logic            last_q;
	logic            valid_q;

	logic [31:0]     mag;
	logic            accept;
	logic            adv;
	logic            bcd_done;
	logic [BW-1:0]   bcd;
	logic [3:0]      top_digit;
	logic [PW-1:0]   prod;
	logic [3:0]      frac_digit;
	logic [3:0]      decs_sat;

	logic            emit;
	logic [6:0]      emit_char;
	logic            emit_last;
	logic            shift_dig;
	logic            frac_step;

	assign accept     = in_valid && !in_stall;
	assign adv        = !valid_q || !out_stall;
	assign mag        = number_value[31] ? (~number_value + 32'd1) : number_value;
	assign top_digit  = dig_q[BW-1 -: fptdt_pkg::DIGIT_W];
	assign prod       = (PW'(frac_q) << 3) + (PW'(frac_q) << 1);
	assign frac_digit = prod[FRAC_BITS +: 4];
	assign decs_sat   = ({1'b0, decimals_q} > 4'(MAX_DECIMALS)) ?
		4'(MAX_DECIMALS) : {1'b0, decimals_q};

	fptdt_bcd #(
		.IN_W   (WB),
		.DIGITS (DIGITS)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (mag[31:FRAC_BITS]),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fptdt_pkg::ST_IDLE: begin
				if (in_valid) state_d = fptdt_pkg::ST_CONV;
			end
			fptdt_pkg::ST_CONV: begin
				if (bcd_done) state_d = fptdt_pkg::ST_SIGN;
			end
			fptdt_pkg::ST_SIGN: begin
				if (!neg_q || adv) state_d = fptdt_pkg::ST_SKIP;
			end
			fptdt_pkg::ST_SKIP: begin
				if (top_digit != 4'd0 || dcnt_q == DC_W'(1)) state_d = fptdt_pkg::ST_INT;
			end
			fptdt_pkg::ST_INT: begin
				if (adv && dcnt_q == DC_W'(1)) begin
					state_d = (decs_q == 4'd0) ? fptdt_pkg::ST_IDLE : fptdt_pkg::ST_DOT;
				end
			end
			fptdt_pkg::ST_DOT: begin
				if (adv) state_d = fptdt_pkg::ST_FRAC;
			end
			fptdt_pkg::ST_FRAC: begin
				if (adv && fcnt_q == 4'd1) state_d = fptdt_pkg::ST_IDLE;
			end
			default: state_d = fptdt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		emit      = 1'b0;
		emit_char = fptdt_pkg::ASCII_ZERO;
		emit_last = 1'b0;
		shift_dig = 1'b0;
		frac_step = 1'b0;
		in_stall  = 1'b1;
		case (state_q)
			fptdt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			fptdt_pkg::ST_SIGN: begin
				emit      = neg_q && adv;
				emit_char = fptdt_pkg::ASCII_MINUS;
			end
			fptdt_pkg::ST_SKIP: begin
				shift_dig = (top_digit == 4'd0) && (dcnt_q != DC_W'(1));
			end
			fptdt_pkg::ST_INT: begin
				emit      = adv;
				emit_char = fptdt_pkg::ASCII_ZERO + 7'(top_digit);
				emit_last = (dcnt_q == DC_W'(1)) && (decs_q == 4'd0);
				shift_dig = adv;
			end
			fptdt_pkg::ST_DOT: begin
				emit      = adv;
				emit_char = fptdt_pkg::ASCII_DOT;
			end
			fptdt_pkg::ST_FRAC: begin
				emit      = adv;
				emit_char = fptdt_pkg::ASCII_ZERO + 7'(frac_digit);
				emit_last = (fcnt_q == 4'd1);
				frac_step = adv;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fptdt_pkg::ST_IDLE;
			decimals_q <= 3'd1;
			valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) decimals_q <= cfg_data;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= number_value[31];
			frac_q <= mag[FW-1:0] & FMASK;
			decs_q <= decs_sat;
			fcnt_q <= decs_sat;
		end else if (frac_step) begin
			frac_q <= prod[FW-1:0] & FMASK;
			fcnt_q <= fcnt_q - 4'd1;
		end
		if (bcd_done) begin
			dig_q  <= bcd;
			dcnt_q <= DC_W'(DIGITS);
		end else if (shift_dig) begin
			dig_q  <= dig_q << fptdt_pkg::DIGIT_W;
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign out_valid = valid_q;
	assign text_char = char_q;
	assign last_char = last_q;

endmodule

[tb/sv/decimal_text_checker.sv]
// ----------------------------------------------------------------------------
// decimal_text_checker
// Watches the number, text and decimal-count ports of the converter, works
// out the decimal text of every accepted number and compares it character
// by character, last flag included, with the characters the converter sends.
// ----------------------------------------------------------------------------
module decimal_text_checker #(
	parameter int FRAC_BITS    = 8,
	parameter int MAX_DECIMALS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] number_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [6:0]  text_char,
	input  logic        last_char,
	output int          fail_count,
	output int          chars_pending
);

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} text_item_t;

	text_item_t expected_text[$];
	text_item_t want;
	logic [2:0] places = 3'd1;
	int         errors = 0;

	function automatic void push_char(input logic [6:0] ch);
		expected_text.push_back('{ch: ch, last: 1'b0});
	endfunction

	function automatic void predict_text(input logic [31:0] value, input logic [2:0] count);
		longint     magnitude;
		longint     whole;
		longint     frac;
		longint     frac_mask;
		int         shown;
		int         ndig;
		int         i;
		logic [3:0] digit_buf[10];
		shown = (int'(count) > MAX_DECIMALS) ? MAX_DECIMALS : int'(count);
		frac_mask = (64'sd1 <<< FRAC_BITS) - 1;
		if (value[31]) begin
			magnitude = 64'sh1_0000_0000 - longint'({32'b0, value});
			push_char(fptdt_pkg::ASCII_MINUS);
		end else begin
			magnitude = longint'({32'b0, value});
		end
		whole = magnitude >>> FRAC_BITS;
		frac = magnitude & frac_mask;
		ndig = 0;
		do begin
			digit_buf[ndig] = 4'(whole % 10);
			whole = whole / 10;
			ndig++;
		end while (whole > 0);
		for (i = ndig - 1; i >= 0; i--)
			push_char(fptdt_pkg::ASCII_ZERO + 7'(digit_buf[i]));
		if (shown > 0) begin
			push_char(fptdt_pkg::ASCII_DOT);
			for (i = 0; i < shown; i++) begin
				frac = frac * 10;
				push_char(fptdt_pkg::ASCII_ZERO + 7'(frac >>> FRAC_BITS));
				frac = frac & frac_mask;
			end
		end
		expected_text[expected_text.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			places = 3'd1;
			expected_text.delete();
		end else begin
			if (in_valid && !in_stall)
				predict_text(number_value, places);
			if (out_valid && !out_stall) begin
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected char, expected none, got %h last %b",
						$time, text_char, last_char);
					errors++;
				end else begin
					want = expected_text.pop_front();
					if (text_char !== want.ch) begin
						$display("%0t: text_char mismatch, expected %h, got %h",
							$time, want.ch, text_char);
						errors++;
					end
					if (last_char !== want.last) begin
						$display("%0t: last_char mismatch, expected %b, got %b",
							$time, want.last, last_char);
						errors++;
					end
				end
			end
			if (cfg_write)
				places = cfg_data;
		end
		fail_count <= errors;
		chars_pending <= expected_text.size();
	end

endmodule

[tb/sv/fixed_point_to_decimal_text_tb.sv]
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_text_tb
// Drives signed fixed-point numbers into the converter under a range of
// decimal counts: a directed set of edge values first, then random numbers
// sent in bursts while the text side stalls on its own pattern, with one
// long hold-off that backs the converter up. The checker does the compare.
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_text_tb;

	localparam int FRAC_BITS          = 8;
	localparam int MAX_DECIMALS       = 6;
	localparam int RANDOM_PER_SETTING = 25;
	localparam int SETTINGS_COUNT     = 6;
	localparam int HOLD_CYCLES        = 400;
	localparam int IDLE_GAP           = 8;
	localparam int END_WAIT           = 60;
	localparam int CYCLE_LIMIT        = 400000;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_write    = 1'b0;
	logic [2:0]  cfg_data     = 3'd0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [31:0] number_value = 32'd0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [6:0]  text_char;
	logic        last_char;

	int fail_count;
	int chars_pending;
	int cycle_count  = 0;
	int burst_left   = 0;
	bit hold_request = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	fixed_point_to_decimal_text #(
		.FRAC_BITS   (FRAC_BITS),
		.MAX_DECIMALS(MAX_DECIMALS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number_value(number_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.text_char   (text_char),
		.last_char   (last_char)
	);

	decimal_text_checker #(
		.FRAC_BITS   (FRAC_BITS),
		.MAX_DECIMALS(MAX_DECIMALS)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.number_value (number_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.text_char    (text_char),
		.last_char    (last_char),
		.fail_count   (fail_count),
		.chars_pending(chars_pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one item per call; the burst ends with a random gap
	task automatic send_item(input logic [31:0] value, input bit end_of_run);
		in_valid <= 1'b1;
		number_value <= value;
		do @(posedge clk); while (in_stall);
		if (burst_left == 0 || end_of_run) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 9);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_batch(input logic [31:0] vals[$]);
		int i;
		for (i = 0; i < vals.size(); i++)
			send_item(vals[i], i == vals.size() - 1);
	endtask

	task automatic wait_idle(input int extra);
		@(posedge clk);
		while (chars_pending != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_decimal_places(input logic [2:0] value);
		wait_idle(IDLE_GAP);
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [31:0] pick_number();
		int unsigned pow10[7];
		logic [31:0] value;
		pow10 = '{1, 10, 100, 1000, 10000, 100000, 1000000};
		case ($urandom_range(0, 5))
			0, 1: value = $urandom();
			2: value = 32'($urandom_range(0, 8191)) - 32'd4096;
			3: value = $urandom() & 32'hFFFF_FF00;
			4: begin
				if ($urandom_range(0, 1))
					value = 32'h7FFF_FFFF - 32'($urandom_range(0, 300));
				else
					value = 32'h8000_0000 + 32'($urandom_range(0, 300));
			end
			default: begin
				value = pow10[$urandom_range(0, 6)];
				if ($urandom_range(0, 1))
					value = value - 32'd1;
				value = (value << 8) | 32'($urandom_range(0, 255));
				if ($urandom_range(0, 1))
					value = -value;
			end
		endcase
		return value;
	endfunction

	initial begin : receiver
		int  rx_cycles;
		int  seg_len;
		int  stall_pct;
		bit  hold_done;
		rx_cycles = 0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			seg_len = $urandom_range(20, 200);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 80;
			endcase
			repeat (seg_len) begin
				@(posedge clk);
				rx_cycles++;
				if (hold_request && !hold_done) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end
				out_stall <= ($urandom_range(1, 100) <= stall_pct);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] batch[$];
		logic [2:0]  places_plan[SETTINGS_COUNT];
		int          seg;
		int          n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset decimal count: zero, tiny fractions, signs, extremes
		batch = '{32'h0000_0000, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0080,
			32'h0000_0100, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FF80,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0098_9680, 32'h0F42_4019};
		send_batch(batch);

		// no fraction part
		set_decimal_places(3'd0);
		batch = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
		send_batch(batch);

		// count above the maximum saturates
		set_decimal_places(3'd7);
		batch = '{32'h0000_00FF, 32'hFFFF_FF01, 32'h1234_5678, 32'h0000_0000};
		send_batch(batch);

		set_decimal_places(3'd6);
		batch = '{32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFF};
		send_batch(batch);

		places_plan = '{3'd6, 3'd0, 3'd7, 3'($urandom_range(1, 5)),
			3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
		for (seg = 0; seg < SETTINGS_COUNT; seg++) begin
			set_decimal_places(places_plan[seg]);
			if (seg == 0)
				hold_request = 1'b1;
			for (n = 0; n < RANDOM_PER_SETTING; n++)
				send_item(pick_number(), n == RANDOM_PER_SETTING - 1);
		end

		wait_idle(END_WAIT);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
